### rtl/core/obdcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obdcf_pkg
// Shared constants and types of the oversampled bit destuffing framer.
// ----------------------------------------------------------------------------
package obdcf_pkg;

    localparam int BUFFER_BYTES = 64;
    localparam int HDR_BYTES    = 6;
    localparam int FLAG_BITS    = 6;
    localparam int CRC_BITS     = 16;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = $clog2((BUFFER_BYTES - HDR_BYTES) * 8 + 1);
    localparam int LIM_W        = (ADDR_W + 1 > 7) ? ADDR_W + 1 : 7;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [7:0]  ONE_PATTERN_RESET  = 8'hC0;
    localparam logic [7:0]  ZERO_PATTERN_RESET = 8'hFC;
    localparam logic [6:0]  BUFFER_LIMIT_RESET = 7'd64;

    localparam logic [1:0] REG_ONE_PATTERN  = 2'd0;
    localparam logic [1:0] REG_ZERO_PATTERN = 2'd1;
    localparam logic [1:0] REG_BUFFER_LIMIT = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic       bit_val;
        logic [3:0] noise;
    } slice_t;

endpackage
`default_nettype wire

### rtl/core/obdcf_slicer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obdcf_slicer
// Decides one oversampled bit by the nearer of two ideal sample patterns.
// ----------------------------------------------------------------------------
module obdcf_slicer
    import obdcf_pkg::*;
(
    input  wire logic [7:0] sample,
    input  wire logic [7:0] one_pattern,
    input  wire logic [7:0] zero_pattern,
    output slice_t          slice
);

    logic [7:0] diff_one;
    logic [7:0] diff_zero;
    logic [3:0] n_one;
    logic [3:0] n_zero;

    assign diff_one  = sample ^ one_pattern;
    assign diff_zero = sample ^ zero_pattern;

    always_comb
    begin
        n_one  = 4'd0;
        n_zero = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n_one  = n_one + {3'd0, diff_one[i]};
            n_zero = n_zero + {3'd0, diff_zero[i]};
        end
        // A tie decodes as a zero.
        slice.bit_val = (n_one < n_zero);
        slice.noise   = (n_one < n_zero) ? n_one : n_zero;
    end

endmodule
`default_nettype wire

### rtl/core/oversampled_bit_destuff_crc_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oversampled_bit_destuff_crc_framer
// Bit destuffing deframer for oversampled serial data with a CRC-16 check.
//
// The s_axis channel carries requests: tuser 0 is a sample byte holding one
// oversampled bit, tuser 1 asks for one byte of the frame buffer. The m_axis
// channel returns frame status at each closing flag (tuser 0) and read data
// (tuser 1). The configuration port writes the two ideal patterns and the
// buffer limit, only while the block is idle: a rule for the user, unenforced.
// Frame bytes sit in one single-port-read buffer memory with a registered
// read. A stored sample passes through the accept, which also reads the
// target byte, and the write back. A read request passes through the accept,
// ST_RD_WAIT and ST_EMIT, which loads the output register. At a closing flag
// the checker walks the m stored bits ahead of the flag from memory, one bit
// a cycle between byte reads, then 16 zero augment bits, a compare, six header
// writes on a pass and the output, with input held off. Reset restores the
// register defaults and clears the bit, ones, raw and noise counters; no
// clearing pass runs, so the buffer stays undefined until written.
// A result waits in the output register while the receiver stalls; the next
// request is accepted meanwhile and holds only if it produces a result
// before the earlier one is taken.
// ----------------------------------------------------------------------------
module oversampled_bit_destuff_crc_framer
    import obdcf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0: sample_byte[7:0], read_address[13:8], zero pad.
    input  wire logic [15:0] s_axis_tdata,
    // Fields from bit 0: req_type.
    input  wire logic        s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Fields from bit 0: frame_valid[0], frame_length[7:1], payload_bits[16:8],
    // noise_total[32:17], raw_bit_total[48:33], read_data[56:49], zero pad.
    output logic [63:0]      m_axis_tdata,
    // Fields from bit 0: result_kind.
    output logic             m_axis_tuser
);

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_RD_WAIT  = 10'b00_0000_0010,
        ST_STORE_WR = 10'b00_0000_0100,
        ST_CK_START = 10'b00_0000_1000,
        ST_CK_RD    = 10'b00_0001_0000,
        ST_CK_BIT   = 10'b00_0010_0000,
        ST_CK_AUG   = 10'b00_0100_0000,
        ST_CK_CMP   = 10'b00_1000_0000,
        ST_HDR_WR   = 10'b01_0000_0000,
        ST_EMIT     = 10'b10_0000_0000
    } state_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic din);
        logic [15:0] shifted;
        shifted = {crc[14:0], din};
        return crc[15] ? (shifted ^ CRC_POLY) : shifted;
    endfunction

    state_t            state_reg, state_next;
    logic [7:0]        one_pat_reg, zero_pat_reg;
    logic [6:0]        limit_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        ones_reg, ones_next;
    logic [15:0]       raw_reg, raw_next;
    logic [15:0]       noise_reg, noise_next;
    logic              bit_reg, bit_next;
    logic              flag_reg, flag_next;
    logic [ADDR_W-1:0] st_addr_reg, st_addr_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  body_reg, body_next;
    logic [15:0]       crc_reg, crc_next;
    logic [15:0]       got_reg, got_next;
    logic [3:0]        aug_reg, aug_next;
    logic [2:0]        hdr_reg, hdr_next;
    logic              ok_reg, ok_next;
    logic              kind_reg, kind_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [63:0]       out_data_reg, out_data_next;

    logic [7:0]        mem [BUFFER_BYTES];
    logic [7:0]        mem_q;
    logic              mem_re, mem_we;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic [7:0]        mem_wdata;

    slice_t            slice;
    logic [LIM_W-1:0]  lim_act;
    logic [LIM_W-1:0]  store_idx;
    logic              store_ok;
    logic              in_fire;
    logic              cur_bit;
    logic [7:0]        hdr_byte;
    logic [15:0]       body16;
    logic [6:0]        frame_len;
    logic [8:0]        pbits;

    obdcf_slicer u_slicer (
        .sample       (s_axis_tdata[7:0]),
        .one_pattern  (one_pat_reg),
        .zero_pattern (zero_pat_reg),
        .slice        (slice)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = out_data_reg;

    assign lim_act   = (LIM_W'(limit_reg) > LIM_W'(BUFFER_BYTES))
                       ? LIM_W'(BUFFER_BYTES) : LIM_W'(limit_reg);
    assign store_idx = LIM_W'(HDR_BYTES) + LIM_W'(cnt_reg >> 3);
    assign store_ok  = store_idx < lim_act;
    assign cur_bit   = mem_q[pos_reg[2:0]];
    assign body16    = 16'(body_reg);
    assign frame_len = ok_reg ? 7'(16'(HDR_BYTES) + ((body16 + 16'd7) >> 3)) : 7'd0;
    assign pbits     = ok_reg ? 9'(body_reg) : 9'd0;

    always_comb
    begin
        case (hdr_reg)
            3'd0:    hdr_byte = body16[7:0];
            3'd1:    hdr_byte = body16[15:8];
            3'd2:    hdr_byte = noise_reg[7:0];
            3'd3:    hdr_byte = noise_reg[15:8];
            3'd4:    hdr_byte = raw_reg[7:0];
            default: hdr_byte = raw_reg[15:8];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ones_next      = ones_reg;
        raw_next       = raw_reg;
        noise_next     = noise_reg;
        bit_next       = bit_reg;
        flag_next      = flag_reg;
        st_addr_next   = st_addr_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        body_next      = body_reg;
        crc_next       = crc_reg;
        got_next       = got_reg;
        aug_next       = aug_reg;
        hdr_next       = hdr_reg;
        ok_next        = ok_reg;
        kind_next      = kind_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        mem_re         = 1'b0;
        mem_raddr      = st_addr_reg;
        mem_we         = 1'b0;
        mem_waddr      = st_addr_reg;
        mem_wdata      = mem_q;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (s_axis_tuser == KIND_READ)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = ADDR_W'(s_axis_tdata[13:8]);
                        rd_ok_next = LIM_W'(s_axis_tdata[13:8]) < LIM_W'(BUFFER_BYTES);
                        kind_next  = KIND_READ;
                        state_next = ST_RD_WAIT;
                    end
                    else
                    begin
                        raw_next   = raw_reg + 16'd1;
                        noise_next = noise_reg + 16'(slice.noise);
                        bit_next   = slice.bit_val;
                        flag_next  = !slice.bit_val && (ones_reg == 8'd4);
                        ones_next  = slice.bit_val ? ones_reg + 8'd1 : 8'd0;
                        st_addr_next = ADDR_W'(store_idx);
                        if (slice.bit_val || ones_reg != 8'd3)
                        begin
                            // Stuffed zeros after three ones are dropped here.
                            if (store_ok)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = ADDR_W'(store_idx);
                                state_next = ST_STORE_WR;
                            end
                            else if (!slice.bit_val && ones_reg == 8'd4)
                            begin
                                state_next = ST_CK_START;
                            end
                        end
                    end
                end
            end

            ST_RD_WAIT:
            begin
                state_next = ST_EMIT;
            end

            ST_STORE_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = st_addr_reg;
                mem_wdata = mem_q;
                mem_wdata[cnt_reg[2:0]] = bit_reg;
                cnt_next  = cnt_reg + CNT_W'(1);
                state_next = flag_reg ? ST_CK_START : ST_IDLE;
            end

            ST_CK_START:
            begin
                kind_next = KIND_STATUS;
                if (cnt_reg < CNT_W'(CRC_BITS + FLAG_BITS))
                begin
                    ok_next    = 1'b0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    n_next     = cnt_reg - CNT_W'(FLAG_BITS);
                    body_next  = cnt_reg - CNT_W'(FLAG_BITS + CRC_BITS);
                    pos_next   = '0;
                    crc_next   = 16'd0;
                    got_next   = 16'd0;
                    state_next = ST_CK_RD;
                end
            end

            ST_CK_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = ADDR_W'(CNT_W'(HDR_BYTES) + (pos_reg >> 3));
                state_next = ST_CK_BIT;
            end

            ST_CK_BIT:
            begin
                if (pos_reg < body_reg)
                begin
                    crc_next = crc_step(crc_reg, cur_bit);
                end
                else
                begin
                    got_next = {cur_bit, got_reg[15:1]};
                end
                pos_next = pos_reg + CNT_W'(1);
                if (pos_reg + CNT_W'(1) == n_reg)
                begin
                    aug_next   = 4'd0;
                    state_next = ST_CK_AUG;
                end
                else if (pos_reg[2:0] == 3'd7)
                begin
                    state_next = ST_CK_RD;
                end
            end

            ST_CK_AUG:
            begin
                crc_next = crc_step(crc_reg, 1'b0);
                aug_next = aug_reg + 4'd1;
                if (aug_reg == 4'd15)
                begin
                    state_next = ST_CK_CMP;
                end
            end

            ST_CK_CMP:
            begin
                ok_next = (crc_reg == got_reg);
                if (crc_reg == got_reg)
                begin
                    hdr_next   = 3'd0;
                    state_next = ST_HDR_WR;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_HDR_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(hdr_reg);
                mem_wdata = hdr_byte;
                hdr_next  = hdr_reg + 3'd1;
                if (hdr_reg == 3'd5)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    if (kind_reg == KIND_READ)
                    begin
                        out_data_next = {7'd0, (rd_ok_reg ? mem_q : 8'd0), 49'd0};
                    end
                    else
                    begin
                        out_data_next = {7'd0, 8'd0, raw_reg, noise_reg, pbits,
                                         frame_len, ok_reg};
                        cnt_next   = '0;
                        raw_next   = 16'd0;
                        noise_next = 16'd0;
                        ones_next  = 8'd0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_pat_reg  <= ONE_PATTERN_RESET;
            zero_pat_reg <= ZERO_PATTERN_RESET;
            limit_reg    <= BUFFER_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ONE_PATTERN:  one_pat_reg  <= cfg_data;
                REG_ZERO_PATTERN: zero_pat_reg <= cfg_data;
                REG_BUFFER_LIMIT: limit_reg    <= cfg_data[6:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ones_reg      <= 8'd0;
            raw_reg       <= 16'd0;
            noise_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ones_reg      <= ones_next;
            raw_reg       <= raw_next;
            noise_reg     <= noise_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg      <= bit_next;
        flag_reg     <= flag_next;
        st_addr_reg  <= st_addr_next;
        pos_reg      <= pos_next;
        n_reg        <= n_next;
        body_reg     <= body_next;
        crc_reg      <= crc_next;
        got_reg      <= got_next;
        aug_reg      <= aug_next;
        hdr_reg      <= hdr_next;
        ok_reg       <= ok_next;
        kind_reg     <= kind_next;
        rd_ok_reg    <= rd_ok_next;
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
    end

    // A passing frame reports a length that matches its payload bit count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_STATUS && m_axis_tdata[0])
        |-> (16'(m_axis_tdata[7:1]) ==
             16'(HDR_BYTES) + ((16'(m_axis_tdata[16:8]) + 16'd7) >> 3)))
        else $error("frame length does not match payload bits");

    // A failing frame reports no length and no payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_STATUS && !m_axis_tdata[0])
        |-> (m_axis_tdata[16:1] == 16'd0))
        else $error("failed frame carries a length");

    // The stored bit count never runs past the buffer.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'((BUFFER_BYTES - HDR_BYTES) * 8))
        else $error("stored bit count past the buffer");

    // An accepted item never leads straight into a bit walk or a header write.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !(state_reg == ST_HDR_WR || state_reg == ST_CK_BIT))
        else $error("check sequence entered straight from an accepted item");

endmodule
`default_nettype wire
